@@ rtl/pdip_pkg.sv @@
// Package for the passive device ID probe: codes, beat types and the type table.
package pdip_pkg;

	// Device type codes.
	localparam logic [3:0] TYPE_NONE       = 4'd0;
	localparam logic [3:0] TYPE_TOUCH      = 4'd1;
	localparam logic [3:0] TYPE_TPOINT     = 4'd2;
	localparam logic [3:0] TYPE_THREE_PART = 4'd3;
	localparam logic [3:0] TYPE_EXPLODE    = 4'd4;
	localparam logic [3:0] TYPE_SERIAL     = 4'd14;

	// ID1 group codes.
	localparam logic [1:0] GROUP_GND       = 2'd0;
	localparam logic [1:0] GROUP_VCC       = 2'd1;
	localparam logic [1:0] GROUP_PULL_DOWN = 2'd2;
	localparam logic [1:0] GROUP_OPEN      = 2'd3;

	// Pin drive codes, shared by ID1 and ID2.
	localparam logic [1:0] DRV_RELEASE = 2'd0;
	localparam logic [1:0] DRV_LOW     = 2'd1;
	localparam logic [1:0] DRV_HIGH    = 2'd2;

	// Input action codes.
	localparam logic ACT_TICK    = 1'b0;
	localparam logic ACT_REMOVED = 1'b1;

	// Configuration.
	localparam int          CFG_ADDR_W        = 2;
	localparam logic [7:0]  DEFAULT_THRESHOLD = 8'd20;
	localparam logic [7:0]  COUNT_MAX         = 8'd255;

	// Probe program steps.
	typedef enum logic [3:0] {
		STEP_START      = 4'd0,
		STEP_SAMPLE_ID2 = 4'd1,
		STEP_CHECK_ID2  = 4'd2,
		STEP_TOUCH_WAIT = 4'd3,
		STEP_CHECK_ID1  = 4'd4,
		STEP_RELEASED   = 4'd5,
		STEP_ID2_HIGH   = 4'd6,
		STEP_SAMPLE_ID1 = 4'd7,
		STEP_EDGE_ID1   = 4'd8,
		STEP_RX_CHECK   = 4'd9,
		STEP_RX_LOW     = 4'd10,
		STEP_FINAL      = 4'd11
	} step_t;

	// Maps an ID1 group (GND, VCC, pull-down) and an ID2 response to a type.
	function automatic logic [3:0] type_lookup(input logic [1:0] grp, input logic [1:0] resp);
		logic [3:0] base;
		unique case (grp)
			GROUP_GND:       base = 4'd5;
			GROUP_VCC:       base = 4'd8;
			GROUP_PULL_DOWN: base = 4'd11;
			default:         base = 4'd0;
		endcase
		return base + {2'b00, resp};
	endfunction

endpackage

@@ rtl/pdip_if.sv @@
// Stream interfaces for the probe's input and result channels.
interface pdip_in_if;
	logic valid;
	logic ready;
	logic action;
	logic id1_level;
	logic id2_level;
	logic rx_level;

	modport source (output valid, action, id1_level, id2_level, rx_level, input ready);
	modport sink   (input valid, action, id1_level, id2_level, rx_level, output ready);
endinterface

interface pdip_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] id1_drive;
	logic       buffer_high;
	logic [1:0] id2_drive;
	logic       rx_drive_low;
	logic [3:0] candidate_type;
	logic [3:0] connected_type;
	logic       affirmed;
	logic       connected_changed;
	logic       serial_mode;

	modport source (output valid, id1_drive, buffer_high, id2_drive, rx_drive_low,
		candidate_type, connected_type, affirmed, connected_changed, serial_mode,
		input ready);
	modport sink (input valid, id1_drive, buffer_high, id2_drive, rx_drive_low,
		candidate_type, connected_type, affirmed, connected_changed, serial_mode,
		output ready);
endinterface

@@ rtl/passive_device_id_probe_unit.sv @@
// Top level of the passive device ID probe sequencer for one accessory port.
//
// Channel   Dir  Beat contents
// in_ch     in   action, id1_level, id2_level, rx_level
// out_ch    out  pin drives, candidate/connected type, status flags
// apb       in   match_threshold at byte address 0
//
// Each input beat is folded into the probe state in the cycle it is accepted,
// and its result beat sits in the output register from the next cycle on, so
// one beat is taken every clock. The only limit is the single output register:
// a new beat is taken whenever that register is empty or is drained in the
// same cycle. Reset (arst_n low) restarts the probe pass, clears all types and
// counts, and loads the default threshold of 20.
module passive_device_id_probe_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	pdip_in_if.sink                         in_ch,
	pdip_out_if.source                      out_ch,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pdip_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	// Configuration register. There is one register, at byte address zero.
	logic [7:0] threshold_q;

	assign pready = 1'b1;
	assign prdata = {24'd0, threshold_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= pdip_pkg::DEFAULT_THRESHOLD;
		end else if (psel && penable && pwrite && (paddr == '0)) begin
			threshold_q <= pwdata[7:0];
		end
	end

	// Probe state.
	pdip_pkg::step_t step_q, step_d;
	logic [1:0] group_q, group_d;
	logic       first_q, first_d;
	logic [3:0] pass_q, pass_d;
	logic [3:0] prev_q, prev_d;
	logic [7:0] count_q, count_d;
	logic [3:0] acc_q, acc_d;
	logic [3:0] rep_q, rep_d;
	logic [1:0] drv_id1_q, drv_id1_d;
	logic       drv_buf_q, drv_buf_d;
	logic [1:0] drv_id2_q, drv_id2_d;
	logic       drv_rx_q, drv_rx_d;
	logic       changed;

	logic out_valid_q;
	logic accept;
	logic advance;
	logic i1, i2, rx;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;
	// The probe program moves only on a tick while no serial device is attached.
	assign advance     = accept && (in_ch.action == pdip_pkg::ACT_TICK) &&
		(acc_q != pdip_pkg::TYPE_SERIAL);
	assign i1 = in_ch.id1_level;
	assign i2 = in_ch.id2_level;
	assign rx = in_ch.rx_level;

	// Next probe step.
	always_comb begin
		step_d = step_q;
		if (advance) begin
			unique case (step_q)
				pdip_pkg::STEP_START:      step_d = pdip_pkg::STEP_SAMPLE_ID2;
				pdip_pkg::STEP_SAMPLE_ID2: step_d = pdip_pkg::STEP_CHECK_ID2;
				pdip_pkg::STEP_CHECK_ID2: begin
					if (first_q && !i2)
						step_d = pdip_pkg::STEP_TOUCH_WAIT;
					else if (!first_q && i2)
						step_d = pdip_pkg::STEP_FINAL;
					else
						step_d = pdip_pkg::STEP_CHECK_ID1;
				end
				pdip_pkg::STEP_TOUCH_WAIT: step_d = pdip_pkg::STEP_FINAL;
				pdip_pkg::STEP_CHECK_ID1: begin
					if (first_q == i1)
						step_d = pdip_pkg::STEP_ID2_HIGH;
					else
						step_d = pdip_pkg::STEP_RELEASED;
				end
				pdip_pkg::STEP_RELEASED:   step_d = pdip_pkg::STEP_ID2_HIGH;
				pdip_pkg::STEP_ID2_HIGH:   step_d = pdip_pkg::STEP_SAMPLE_ID1;
				pdip_pkg::STEP_SAMPLE_ID1: step_d = pdip_pkg::STEP_EDGE_ID1;
				pdip_pkg::STEP_EDGE_ID1: begin
					if (first_q != i1)
						step_d = pdip_pkg::STEP_FINAL;
					else
						step_d = pdip_pkg::STEP_RX_CHECK;
				end
				pdip_pkg::STEP_RX_CHECK: begin
					if (rx)
						step_d = pdip_pkg::STEP_RX_LOW;
					else
						step_d = pdip_pkg::STEP_FINAL;
				end
				pdip_pkg::STEP_RX_LOW:     step_d = pdip_pkg::STEP_FINAL;
				pdip_pkg::STEP_FINAL:      step_d = pdip_pkg::STEP_START;
				default:                   step_d = pdip_pkg::STEP_START;
			endcase
		end
	end

	// Pin drives, classification and debounce for the step being executed.
	always_comb begin
		group_d   = group_q;
		first_d   = first_q;
		pass_d    = pass_q;
		prev_d    = prev_q;
		count_d   = count_q;
		acc_d     = acc_q;
		rep_d     = rep_q;
		drv_id1_d = drv_id1_q;
		drv_buf_d = drv_buf_q;
		drv_id2_d = drv_id2_q;
		drv_rx_d  = drv_rx_q;

		if (advance) begin
			unique case (step_q)
				pdip_pkg::STEP_START: begin
					pass_d    = pdip_pkg::TYPE_NONE;
					group_d   = pdip_pkg::GROUP_OPEN;
					drv_id1_d = pdip_pkg::DRV_HIGH;
					drv_buf_d = 1'b0;
					drv_id2_d = pdip_pkg::DRV_RELEASE;
				end
				pdip_pkg::STEP_SAMPLE_ID2: begin
					first_d   = i2;
					drv_id1_d = pdip_pkg::DRV_LOW;
				end
				pdip_pkg::STEP_CHECK_ID2: begin
					if (first_q && !i2) begin
						pass_d    = pdip_pkg::TYPE_TOUCH;
						drv_buf_d = 1'b1;
						drv_id1_d = pdip_pkg::DRV_RELEASE;
					end else if (!first_q && i2) begin
						pass_d = pdip_pkg::TYPE_TPOINT;
					end else begin
						first_d   = i1;
						drv_id1_d = pdip_pkg::DRV_HIGH;
					end
				end
				pdip_pkg::STEP_TOUCH_WAIT: begin
				end
				pdip_pkg::STEP_CHECK_ID1: begin
					if (first_q && i1) begin
						group_d = pdip_pkg::GROUP_VCC;
					end else if (!first_q && !i1) begin
						group_d = pdip_pkg::GROUP_GND;
					end else begin
						drv_buf_d = 1'b1;
						drv_id1_d = pdip_pkg::DRV_RELEASE;
					end
				end
				pdip_pkg::STEP_RELEASED: begin
					group_d = i1 ? pdip_pkg::GROUP_OPEN : pdip_pkg::GROUP_PULL_DOWN;
				end
				pdip_pkg::STEP_ID2_HIGH: begin
					drv_buf_d = 1'b1;
					drv_id1_d = pdip_pkg::DRV_RELEASE;
					drv_id2_d = pdip_pkg::DRV_HIGH;
				end
				pdip_pkg::STEP_SAMPLE_ID1: begin
					first_d   = i1;
					drv_id2_d = pdip_pkg::DRV_LOW;
				end
				pdip_pkg::STEP_EDGE_ID1: begin
					if (first_q && !i1) begin
						// A falling ID1 only means three-part when ID1 floats.
						if (group_q == pdip_pkg::GROUP_OPEN)
							pass_d = pdip_pkg::TYPE_THREE_PART;
					end else if (!first_q && i1) begin
						pass_d = pdip_pkg::TYPE_EXPLODE;
					end else begin
						drv_id1_d = pdip_pkg::DRV_HIGH;
						drv_buf_d = 1'b0;
						drv_id2_d = pdip_pkg::DRV_HIGH;
					end
				end
				pdip_pkg::STEP_RX_CHECK: begin
					drv_rx_d = 1'b0;
					if (rx) begin
						drv_id2_d = pdip_pkg::DRV_LOW;
						drv_rx_d  = 1'b1;
					end else if (group_q == pdip_pkg::GROUP_OPEN) begin
						pass_d = pdip_pkg::TYPE_SERIAL;
					end else begin
						pass_d = pdip_pkg::type_lookup(group_q, pdip_pkg::GROUP_GND);
					end
				end
				pdip_pkg::STEP_RX_LOW: begin
					drv_rx_d = 1'b0;
					if (group_q != pdip_pkg::GROUP_OPEN)
						pass_d = pdip_pkg::type_lookup(group_q,
							rx ? pdip_pkg::GROUP_VCC : pdip_pkg::GROUP_PULL_DOWN);
				end
				pdip_pkg::STEP_FINAL: begin
					// End of pass: park the pins and debounce the pass result.
					drv_id2_d = pdip_pkg::DRV_RELEASE;
					drv_id1_d = pdip_pkg::DRV_HIGH;
					drv_buf_d = 1'b0;
					if (pass_q == prev_q) begin
						count_d = (count_q == pdip_pkg::COUNT_MAX) ? count_q :
							count_q + 8'd1;
						if (count_d >= threshold_q)
							acc_d = pass_q;
					end else begin
						count_d = 8'd0;
					end
					prev_d = pass_q;
				end
				default: begin
				end
			endcase
		end

		// Removal clears the accepted type but leaves the reported one alone;
		// a tick reports whatever is accepted after it.
		if (accept && (in_ch.action == pdip_pkg::ACT_REMOVED))
			acc_d = pdip_pkg::TYPE_NONE;
		changed = (acc_d != rep_q);
		if (accept && (in_ch.action == pdip_pkg::ACT_TICK))
			rep_d = acc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= pdip_pkg::STEP_START;
			group_q   <= pdip_pkg::GROUP_OPEN;
			first_q   <= 1'b0;
			pass_q    <= pdip_pkg::TYPE_NONE;
			prev_q    <= pdip_pkg::TYPE_NONE;
			count_q   <= 8'd0;
			acc_q     <= pdip_pkg::TYPE_NONE;
			rep_q     <= pdip_pkg::TYPE_NONE;
			drv_id1_q <= pdip_pkg::DRV_RELEASE;
			drv_buf_q <= 1'b1;
			drv_id2_q <= pdip_pkg::DRV_RELEASE;
			drv_rx_q  <= 1'b0;
		end else begin
			step_q    <= step_d;
			group_q   <= group_d;
			first_q   <= first_d;
			pass_q    <= pass_d;
			prev_q    <= prev_d;
			count_q   <= count_d;
			acc_q     <= acc_d;
			rep_q     <= rep_d;
			drv_id1_q <= drv_id1_d;
			drv_buf_q <= drv_buf_d;
			drv_id2_q <= drv_id2_d;
			drv_rx_q  <= drv_rx_d;
		end
	end

	// Result register: loaded with the post-beat state on every accepted beat.
	logic [1:0] res_id1_q;
	logic       res_buf_q;
	logic [1:0] res_id2_q;
	logic       res_rx_q;
	logic [3:0] res_cand_q;
	logic [3:0] res_conn_q;
	logic       res_aff_q;
	logic       res_chg_q;
	logic       res_ser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_id1_q  <= drv_id1_d;
			res_buf_q  <= drv_buf_d;
			res_id2_q  <= drv_id2_d;
			res_rx_q   <= drv_rx_d;
			res_cand_q <= prev_d;
			res_conn_q <= acc_d;
			res_aff_q  <= (count_d >= threshold_q);
			res_chg_q  <= changed;
			res_ser_q  <= (acc_d == pdip_pkg::TYPE_SERIAL);
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.id1_drive         = res_id1_q;
	assign out_ch.buffer_high       = res_buf_q;
	assign out_ch.id2_drive         = res_id2_q;
	assign out_ch.rx_drive_low      = res_rx_q;
	assign out_ch.candidate_type    = res_cand_q;
	assign out_ch.connected_type    = res_conn_q;
	assign out_ch.affirmed          = res_aff_q;
	assign out_ch.connected_changed = res_chg_q;
	assign out_ch.serial_mode       = res_ser_q;

endmodule
